>>> hdl/gmps_pkg.sv
// Shared types and constants for the grid max path sum block.
// No dependencies; compiled first.
package gmps_pkg;

  localparam int CELL_W   = 16;
  localparam int SCORE_W  = 26;
  localparam int ROWS_W   = 7;
  localparam int COLS_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_IN_USE    = 1'b0,
    REG_COLUMNS_IN_USE = 1'b1
  } gmps_reg_t;

  // Raw configuration as written by software
  typedef struct packed {
    logic [ROWS_W-1:0] rows_in_use;
    logic [COLS_W-1:0] columns_in_use;
  } gmps_cfg_t;

  // Result leaving the scoring pipeline
  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] best_total;
  } gmps_res_t;

endpackage

>>> hdl/gmps_in_if.sv
// Input channel: one grid cell per beat.
// Depends on gmps_pkg.
interface gmps_in_if;
  logic                       valid;
  logic                       ready;
  logic [gmps_pkg::CELL_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

>>> hdl/gmps_out_if.sv
// Result channel: one best path total per beat.
// Depends on gmps_pkg.
interface gmps_out_if;
  logic                        valid;
  logic                        ready;
  logic [gmps_pkg::SCORE_W-1:0] best_total;

  modport source (output valid, output best_total, input ready);
  modport sink   (input valid, input best_total, output ready);
endinterface

>>> hdl/gmps_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on gmps_pkg.
interface gmps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gmps_pkg::CFG_IDX_W-1:0] index;
  logic [gmps_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/grid_max_path_sum.sv
// Grid max path sum: top level with config registers and result register.
// A result leaves via the stage B registers and then the output register.
// Throughput: one cell per cycle unless held, set by column score memory
// (two reads at accept, one write as stage B completes, with forwarding).
// Reset: counters and running best cleared, rows 64 / columns 1024;
// the score memory is not cleared and needs no clearing pass.
module grid_max_path_sum #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  gmps_in_if.sink     in_ch,
  gmps_out_if.source  out_ch,
  gmps_cfg_if.sink    cfg_ch
);
  import gmps_pkg::*;

  gmps_cfg_t          cfg_r;
  gmps_res_t          res;
  logic               hold;
  logic               out_valid_r;
  logic [SCORE_W-1:0] out_best_r;

  // Config writes, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_in_use    <= ROWS_W'(64);
      cfg_r.columns_in_use <= COLS_W'(1024);
    end else if (cfg_ch.valid) begin
      unique case (gmps_reg_t'(cfg_ch.index))
        REG_ROWS_IN_USE:    cfg_r.rows_in_use    <= cfg_ch.data[ROWS_W-1:0];
        REG_COLUMNS_IN_USE: cfg_r.columns_in_use <= cfg_ch.data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall the pipeline only when a second result meets a waiting one
  assign hold = res.valid && out_valid_r && !out_ch.ready;

  gmps_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_cell_value (in_ch.cell_value),
    .hold          (hold),
    .res           (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && !hold) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && !hold)
      out_best_r <= res.best_total;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.best_total = out_best_r;

endmodule

>>> hdl/gmps_core.sv
// Scoring pipeline: row/column counters, column score memory, best tracking.
// Depends on gmps_pkg.
module gmps_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gmps_pkg::gmps_cfg_t          cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gmps_pkg::CELL_W-1:0]  in_cell_value,
  input  logic                         hold,
  output gmps_pkg::gmps_res_t          res
);
  import gmps_pkg::*;

  localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CSW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CCW = $clog2(MAX_COLS + 1);

  // Column score memory: two reads at accept, one write at completion
  logic [SCORE_W-1:0] score_mem [MAX_ROWS];

  logic [AW-1:0]  row_cnt_r, row_cnt_nxt;
  logic [CSW-1:0] col_cnt_r, col_cnt_nxt;

  logic [RCW-1:0] rows, r_inc;
  logic [CCW-1:0] cols, col_inc;
  logic [AW-1:0]  r, addr1;
  logic           has_down, has_up, first_col, last_col, col_end, grid_end;
  logic           accept, b_done;

  // Stage B registers
  logic               b_valid_r;
  logic [CELL_W-1:0]  b_value_r;
  logic [AW-1:0]      b_addr_r;
  logic               b_first_r, b_last_r, b_up_r, b_down_r, b_end_r;
  logic [SCORE_W-1:0] rd0_r, rd1_r, fwd_score_r;
  logic               fwd0_r, fwd1_r;
  logic [SCORE_W-1:0] upper_r, best_r;

  logic [SCORE_W-1:0] old_here, down_score, nb_best, score, best_nxt;
  logic [SCORE_W:0]   sum;

  // Clamp the configured counts to their usable ranges
  always_comb begin
    if (cfg.rows_in_use == '0)
      rows = RCW'(1);
    else if (32'(cfg.rows_in_use) > MAX_ROWS)
      rows = RCW'(MAX_ROWS);
    else
      rows = RCW'(cfg.rows_in_use);

    if (cfg.columns_in_use == '0)
      cols = CCW'(1);
    else if (32'(cfg.columns_in_use) > MAX_COLS)
      cols = CCW'(MAX_COLS);
    else
      cols = CCW'(cfg.columns_in_use);
  end

  // Position of the incoming cell and counter advance
  always_comb begin
    r         = (RCW'(row_cnt_r) >= rows) ? AW'(rows - RCW'(1)) : row_cnt_r;
    r_inc     = RCW'(r) + RCW'(1);
    has_down  = r_inc < rows;
    has_up    = r != '0;
    addr1     = has_down ? AW'(r_inc) : r;
    first_col = col_cnt_r == '0;
    col_inc   = CCW'(col_cnt_r) + CCW'(1);
    last_col  = col_inc >= cols;
    col_end   = r_inc >= rows;
    grid_end  = col_end && last_col;

    row_cnt_nxt = col_end ? '0 : AW'(r_inc);
    if (col_end)
      col_cnt_nxt = last_col ? '0 : CSW'(col_inc);
    else
      col_cnt_nxt = col_cnt_r;
  end

  assign in_ready = !hold;
  assign accept   = in_valid && in_ready;
  assign b_done   = b_valid_r && !hold;

  // Score of the cell in stage B, with forwarding of the write in flight
  always_comb begin
    old_here   = fwd0_r ? fwd_score_r : rd0_r;
    down_score = fwd1_r ? fwd_score_r : rd1_r;
    nb_best    = old_here;
    if (b_up_r && upper_r > nb_best)
      nb_best = upper_r;
    if (b_down_r && down_score > nb_best)
      nb_best = down_score;
    sum = {1'b0, nb_best} + (SCORE_W + 1)'(b_value_r);
    if (b_first_r)
      score = SCORE_W'(b_value_r);
    else if (sum[SCORE_W])
      score = '1;
    else
      score = sum[SCORE_W-1:0];

    // First row of a first-grid-column restarts the running best
    if (!b_up_r || score > best_r)
      best_nxt = score;
    else
      best_nxt = best_r;
  end

  assign res.valid      = b_valid_r && b_end_r;
  assign res.best_total = best_nxt;

  // Memory port
  always_ff @(posedge clk) begin
    if (b_done)
      score_mem[b_addr_r] <= score;
    if (accept) begin
      rd0_r <= score_mem[r];
      rd1_r <= score_mem[addr1];
    end
  end

  // Stage B payload
  always_ff @(posedge clk) begin
    if (accept) begin
      b_value_r   <= in_cell_value;
      b_addr_r    <= r;
      b_first_r   <= first_col;
      b_last_r    <= last_col;
      b_up_r      <= has_up;
      b_down_r    <= has_down;
      b_end_r     <= grid_end;
      fwd0_r      <= b_done && (b_addr_r == r);
      fwd1_r      <= b_done && (b_addr_r == addr1);
      fwd_score_r <= score;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      upper_r   <= '0;
      best_r    <= '0;
    end else begin
      if (!hold)
        b_valid_r <= accept;
      if (accept) begin
        row_cnt_r <= row_cnt_nxt;
        col_cnt_r <= col_cnt_nxt;
      end
      if (b_done) begin
        upper_r <= b_end_r ? '0 : old_here;
        if (b_end_r)
          best_r <= '0;
        else if (b_last_r)
          best_r <= best_nxt;
      end
    end
  end

endmodule

>>> dv/tb_grid_max_path_sum.sv
// Self-checking testbench for grid_max_path_sum: streams grids of cells, predicts
// each best path total in a local scoring model, and checks every result beat.
// Depends on gmps_pkg, the gmps_*_if interfaces and the grid_max_path_sum RTL.
module tb_grid_max_path_sum;
  import gmps_pkg::*;

  localparam int GRID_ROWS_MAX = 64;
  localparam int GRID_COLS_MAX = 1024;
  localparam int RANDOM_CELLS  = 250;
  localparam int STALL_AFTER   = 100;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_STALL    = 400;
  localparam int CYCLE_LIMIT   = 500000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  logic clk;
  logic rst_n;

  gmps_in_if  cell_ch ();
  gmps_out_if total_ch ();
  gmps_cfg_if reg_ch ();

  grid_max_path_sum #(
    .MAX_ROWS(GRID_ROWS_MAX),
    .MAX_COLS(GRID_COLS_MAX)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (cell_ch),
    .out_ch(total_ch),
    .cfg_ch(reg_ch)
  );

  // Scoring model state
  logic [ROWS_W-1:0]  rows_reg = ROWS_W'(GRID_ROWS_MAX);
  logic [COLS_W-1:0]  cols_reg = COLS_W'(GRID_COLS_MAX);
  logic [SCORE_W-1:0] score_line [GRID_ROWS_MAX];
  logic [SCORE_W-1:0] above_prev = '0;
  logic [SCORE_W-1:0] first_col_best = '0;
  int unsigned        row_pos = 0;
  int unsigned        col_pos = 0;

  logic [CELL_W-1:0]  pending_cells [$];
  logic [SCORE_W-1:0] expected_totals [$];

  int  errors = 0;
  int  cycle_count = 0;
  bit  cell_beat = 1'b0;
  bit  bursts_on = 1'b1;
  bit  stall_req = 1'b0;
  int  stall_left = 0;
  int  cell_gap = 0;
  int  sink_gap = 0;

  function automatic int unsigned effective_count(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the scoring model by one cell; returns 1 when a grid completes
  function automatic bit score_cell(input logic [CELL_W-1:0] gold,
                                    output logic [SCORE_W-1:0] total);
    int unsigned        n_rows;
    int unsigned        n_cols;
    int unsigned        r;
    logic [SCORE_W-1:0] here_prev;
    logic [SCORE_W-1:0] best;
    logic [SCORE_W-1:0] score;
    logic [SCORE_W:0]   sum;
    n_rows = effective_count(rows_reg, GRID_ROWS_MAX);
    n_cols = effective_count(cols_reg, GRID_COLS_MAX);
    // row counter past a shrunken row count lands on the last row
    r = (row_pos >= n_rows) ? n_rows - 1 : row_pos;
    here_prev = score_line[r];
    total = '0;
    if (col_pos == 0) begin
      score = SCORE_W'(gold);
    end else begin
      best = here_prev;
      if (r > 0 && above_prev > best) best = above_prev;
      if (r + 1 < n_rows && score_line[r + 1] > best) best = score_line[r + 1];
      sum = {1'b0, best} + (SCORE_W + 1)'(gold);
      score = (sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[SCORE_W-1:0];
    end
    above_prev = here_prev;
    score_line[r] = score;
    // first grid column: track the best score, restarting on its top row
    if (col_pos + 1 >= n_cols) begin
      if (r == 0 || score > first_col_best) first_col_best = score;
    end
    row_pos = r + 1;
    if (row_pos >= n_rows) begin
      row_pos = 0;
      col_pos++;
      if (col_pos >= n_cols) begin
        total = first_col_best;
        col_pos = 0;
        first_col_best = '0;
        above_prev = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Clock, reset and known input levels from time zero
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cell_ch.valid = 1'b0;
    cell_ch.cell_value = '0;
    total_ch.ready = 1'b0;
    reg_ch.valid = 1'b0;
    reg_ch.index = REG_ROWS_IN_USE;
    reg_ch.data = '0;
    foreach (score_line[i]) score_line[i] = '0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
      end
    join_none
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Cell driver: next beat once the current one is taken, with idle bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      cell_ch.valid <= 1'b0;
    end else if (!cell_ch.valid || cell_beat) begin
      if (cell_gap > 0) begin
        cell_gap--;
        cell_ch.valid <= 1'b0;
      end else if (pending_cells.size() > 0) begin
        cell_ch.valid <= 1'b1;
        cell_ch.cell_value <= pending_cells.pop_front();
        if (bursts_on && $urandom_range(0, 9) == 0) cell_gap = $urandom_range(1, 17);
      end else begin
        cell_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random backpressure bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      total_ch.ready <= 1'b0;
    end else begin
      if (stall_req) begin
        stall_left = LONG_STALL;
        stall_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        total_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        total_ch.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 11) == 0) begin
        sink_gap = $urandom_range(0, 16);
        total_ch.ready <= 1'b0;
      end else begin
        total_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each cell beat, compare each result beat in order
  always @(posedge clk) begin
    logic [SCORE_W-1:0] total_now;
    logic [SCORE_W-1:0] want;
    if (rst_n) begin
      cell_beat = cell_ch.valid && cell_ch.ready;
      if (cell_beat) begin
        if (score_cell(cell_ch.cell_value, total_now)) expected_totals.push_back(total_now);
      end
      if (total_ch.valid && total_ch.ready) begin
        if (expected_totals.size() == 0) begin
          $display("%0t: best_total expected none, got %0d", $time, total_ch.best_total);
          errors++;
        end else begin
          want = expected_totals.pop_front();
          if (total_ch.best_total !== want) begin
            $display("%0t: best_total expected %0d, got %0d", $time, want,
                     total_ch.best_total);
            errors++;
          end
        end
      end
    end
  end

  // Register write; the model picks it up on the accepting edge
  task automatic write_reg(input gmps_reg_t idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data <= val;
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    case (idx)
      REG_ROWS_IN_USE:    rows_reg = val[ROWS_W-1:0];
      REG_COLUMNS_IN_USE: cols_reg = val[COLS_W-1:0];
      default: ;
    endcase
    @(negedge clk) reg_ch.valid <= 1'b0;
  endtask

  // Grid shape write, sometimes through out-of-range raw values
  task automatic configure_grid(input int rows, input int cols);
    logic [CFG_DAT_W-1:0] rows_data;
    logic [CFG_DAT_W-1:0] cols_data;
    rows_data = CFG_DAT_W'($urandom());
    rows_data[ROWS_W-1:0] = ROWS_W'(rows);
    if (rows == 1 && $urandom_range(0, 3) == 0)
      rows_data[ROWS_W-1:0] = '0;
    else if (rows == GRID_ROWS_MAX && $urandom_range(0, 1) == 1)
      rows_data[ROWS_W-1:0] = ROWS_W'($urandom_range(GRID_ROWS_MAX + 1, 127));
    cols_data = CFG_DAT_W'(cols);
    if (cols == 1 && $urandom_range(0, 3) == 0)
      cols_data = '0;
    else if (cols == GRID_COLS_MAX && $urandom_range(0, 1) == 1)
      cols_data = CFG_DAT_W'($urandom_range(GRID_COLS_MAX + 1, 2047));
    write_reg(REG_ROWS_IN_USE, rows_data);
    write_reg(REG_COLUMNS_IN_USE, cols_data);
  endtask

  task automatic queue_cells(input int count, input bit all_max);
    logic [CELL_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 15))
        0:       v = '0;
        1:       v = '1;
        default: v = CELL_W'($urandom());
      endcase
      pending_cells.push_back(all_max ? {CELL_W{1'b1}} : v);
    end
  endtask

  // Sender pause: all cells taken, all totals back, then the pipeline settles
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cells.size() != 0 || cell_ch.valid || expected_totals.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int rows;
    int cols;
    int cells;
    int cells_sent;
    bit stall_done;
    cells_sent = 0;
    stall_done = 1'b0;
    wait (rst_n);
    @(posedge clk);

    // reset shape, then shrink rows and columns in mid-column
    pending_cells.push_back(16'd0);
    pending_cells.push_back(16'hFFFF);
    pending_cells.push_back(16'd1);
    wait_idle();
    write_reg(REG_ROWS_IN_USE, 11'd2);
    write_reg(REG_COLUMNS_IN_USE, 11'd2);
    pending_cells.push_back(16'hFFFF);
    pending_cells.push_back(16'd0);
    pending_cells.push_back(16'hFFFF);
    wait_idle();

    // zero counts act as one: every cell is a whole grid
    write_reg(REG_ROWS_IN_USE, 11'h780);
    write_reg(REG_COLUMNS_IN_USE, 11'd0);
    pending_cells.push_back(16'd0);
    pending_cells.push_back(16'hFFFF);
    wait_idle();

    // small square grid
    write_reg(REG_ROWS_IN_USE, 11'd3);
    write_reg(REG_COLUMNS_IN_USE, 11'd3);
    queue_cells(9, 1'b0);
    wait_idle();

    // column count cut below the current column counter in mid-grid
    write_reg(REG_ROWS_IN_USE, 11'd2);
    write_reg(REG_COLUMNS_IN_USE, 11'd5);
    queue_cells(4, 1'b0);
    wait_idle();
    write_reg(REG_COLUMNS_IN_USE, 11'd2);
    queue_cells(2, 1'b0);
    wait_idle();

    // full-height grids, then a wide one with every cell at full scale
    write_reg(REG_ROWS_IN_USE, 11'h7E4);
    write_reg(REG_COLUMNS_IN_USE, 11'd1);
    queue_cells(GRID_ROWS_MAX, 1'b0);
    wait_idle();
    configure_grid(GRID_ROWS_MAX, 2);
    queue_cells(2 * GRID_ROWS_MAX, 1'b0);
    wait_idle();
    write_reg(REG_ROWS_IN_USE, 11'd1);
    write_reg(REG_COLUMNS_IN_USE, 11'd256);
    queue_cells(256, 1'b1);
    wait_idle();

    // random shapes, mostly whole grids, some left unfinished
    while (cells_sent < RANDOM_CELLS) begin
      if (!stall_done && cells_sent >= STALL_AFTER) begin
        // long result hold-off while one-cell grids keep coming
        configure_grid(1, 1);
        stall_req = 1'b1;
        queue_cells(150, 1'b0);
        wait_idle();
        stall_done = 1'b1;
      end
      case ($urandom_range(0, 19))
        0: begin
          rows = GRID_ROWS_MAX;
          cols = $urandom_range(1, 2);
        end
        1, 2, 3: begin
          rows = 1;
          cols = $urandom_range(1, 40);
        end
        default: begin
          rows = $urandom_range(2, 8);
          cols = $urandom_range(1, 12);
        end
      endcase
      // an unfinished grid may only keep or lose rows
      if ((row_pos != 0 || col_pos != 0) && rows > effective_count(rows_reg, GRID_ROWS_MAX))
        rows = effective_count(rows_reg, GRID_ROWS_MAX);
      configure_grid(rows, cols);
      cells = $urandom_range(1, 3) * rows * cols;
      if (rows * cols > 1 && $urandom_range(0, 5) == 0)
        cells += $urandom_range(1, rows * cols - 1);
      bursts_on = ($urandom_range(0, 4) != 0);
      queue_cells(cells, 1'b0);
      cells_sent += cells;
      wait_idle();
    end

    // closing stretch with no idle cycles on either side
    bursts_on = 1'b0;
    cell_gap = 0;
    sink_gap = 0;
    rows = $urandom_range(1, 4);
    if ((row_pos != 0 || col_pos != 0) && rows > effective_count(rows_reg, GRID_ROWS_MAX))
      rows = effective_count(rows_reg, GRID_ROWS_MAX);
    cols = $urandom_range(1, 6);
    configure_grid(rows, cols);
    queue_cells(((60 / (rows * cols)) + 1) * rows * cols, 1'b0);
    wait_idle();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> grid_max_path_sum.f
hdl/gmps_pkg.sv
hdl/gmps_in_if.sv
hdl/gmps_out_if.sv
hdl/gmps_cfg_if.sv
hdl/gmps_core.sv
hdl/grid_max_path_sum.sv
dv/tb_grid_max_path_sum.sv
